FILE: hw/rtl/hlls_pkg.sv
// ----------------------------------------------------------------------------
// hlls_pkg
// Shared constants, scan phase codes and character helpers for the hex
// literal line statistics block.
// ----------------------------------------------------------------------------
package hlls_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int VALUE_W    = 64;
	localparam int COUNT_W    = 16;
	localparam int DIV_W      = VALUE_W + FRAC_BITS;
	localparam int STEP_W     = $clog2(DIV_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;

	localparam logic KIND_LITERAL = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ZERO   = 2'd1,
		PH_PREFIX = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LIT  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_SUM  = 4'b1000
	} state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			h.val = 4'(c - CH_ZERO);
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.val = 4'(c - CH_UA) + 4'd10;
		end else if (c >= CH_LA && c <= CH_LF) begin
			h.val = 4'(c - CH_LA) + 4'd10;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: hw/rtl/hex_literal_line_stats.sv
// ----------------------------------------------------------------------------
// hex_literal_line_stats
// Scans a byte stream for 0x hex literals, reports each literal and, at each
// newline, the line maximum, fixed-point mean and literal count.
// ----------------------------------------------------------------------------
// Latency: a literal result is presented the cycle after its ending byte.
// A summary is presented after restoring division (64 whole + 8 fraction
// quotient bits, one per cycle); an empty line skips the division.
// Throughput: one byte per cycle while no result is pending; the request side
// stalls while a result waits or the divider runs.
// Reset (arst_n low) clears the sequencer, scan phase and line accumulators.
module hex_literal_line_stats (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  char_code,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        kind,
	output logic [63:0] value,
	output logic [63:0] mean_whole,
	output logic [7:0]  mean_frac,
	output logic [15:0] number_count,
	output logic        last
);

	hlls_pkg::state_t state_q;
	hlls_pkg::phase_t phase_q;
	logic [hlls_pkg::VALUE_W-1:0] acc_q;
	logic [hlls_pkg::VALUE_W-1:0] max_q;
	logic [hlls_pkg::VALUE_W-1:0] sum_q;
	logic [hlls_pkg::COUNT_W-1:0] cnt_q;
	logic pend_nl_q;

	logic [hlls_pkg::DIV_W-1:0] quo_q;
	logic [hlls_pkg::COUNT_W-1:0] rem_q;
	logic [hlls_pkg::STEP_W-1:0] step_q;

	logic [hlls_pkg::VALUE_W-1:0] sum_new;
	logic [hlls_pkg::VALUE_W-1:0] max_new;
	logic [hlls_pkg::COUNT_W-1:0] cnt_new;

	hlls_pkg::hex_t hx;
	logic req_acc, rsp_acc;
	logic lit_end, is_nl, sum_start;
	logic [hlls_pkg::COUNT_W:0] rem_sh;
	logic rem_ge;

	assign req_stall = (state_q != hlls_pkg::ST_IDLE);
	assign rsp_valid = (state_q == hlls_pkg::ST_LIT) || (state_q == hlls_pkg::ST_SUM);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_acc   = rsp_valid && !rsp_stall;

	always_comb begin
		hx      = hlls_pkg::hex_decode(char_code);
		is_nl   = (char_code == hlls_pkg::CH_NL);
		lit_end = (phase_q == hlls_pkg::PH_DIGITS) && !hx.ok;
		sum_start = 1'b0;
		if (req_acc && char_code != hlls_pkg::CH_NUL && is_nl && !lit_end) begin
			sum_start = 1'b1;
		end
		if (state_q == hlls_pkg::ST_LIT && rsp_acc && pend_nl_q) begin
			sum_start = 1'b1;
		end
		sum_new = sum_q + acc_q;
		max_new = (acc_q > max_q) ? acc_q : max_q;
		cnt_new = (cnt_q != hlls_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		rem_sh  = {rem_q, quo_q[hlls_pkg::DIV_W-1]};
		rem_ge  = (rem_sh >= {1'b0, cnt_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hlls_pkg::ST_IDLE;
			phase_q      <= hlls_pkg::PH_IDLE;
			acc_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			pend_nl_q    <= 1'b0;
			step_q       <= '0;
			quo_q        <= '0;
			rem_q        <= '0;
			kind         <= hlls_pkg::KIND_LITERAL;
			value        <= '0;
			mean_whole   <= '0;
			mean_frac    <= '0;
			number_count <= '0;
			last         <= 1'b0;
		end else begin
			unique case (state_q)
				hlls_pkg::ST_IDLE: begin
					if (req_acc) begin
						if (char_code == hlls_pkg::CH_NUL) begin
							phase_q <= hlls_pkg::PH_IDLE;
							acc_q   <= '0;
							max_q   <= '0;
							sum_q   <= '0;
							cnt_q   <= '0;
						end else if (phase_q == hlls_pkg::PH_DIGITS && hx.ok) begin
							acc_q <= {acc_q[hlls_pkg::VALUE_W-5:0], hx.val};
						end else if (phase_q == hlls_pkg::PH_ZERO &&
								char_code == hlls_pkg::CH_X) begin
							phase_q <= hlls_pkg::PH_PREFIX;
						end else if (phase_q == hlls_pkg::PH_PREFIX && hx.ok) begin
							acc_q   <= hlls_pkg::VALUE_W'(hx.val);
							phase_q <= hlls_pkg::PH_DIGITS;
						end else begin
							phase_q <= (char_code == hlls_pkg::CH_ZERO) ?
								hlls_pkg::PH_ZERO : hlls_pkg::PH_IDLE;
							if (lit_end) begin
								kind         <= hlls_pkg::KIND_LITERAL;
								value        <= acc_q;
								mean_whole   <= '0;
								mean_frac    <= '0;
								number_count <= '0;
								last         <= !is_nl;
								max_q        <= max_new;
								sum_q        <= sum_new;
								cnt_q        <= cnt_new;
								acc_q        <= '0;
								pend_nl_q    <= is_nl;
								state_q      <= hlls_pkg::ST_LIT;
							end
						end
					end
				end
				hlls_pkg::ST_LIT: begin
					if (rsp_acc && !pend_nl_q) begin
						state_q <= hlls_pkg::ST_IDLE;
					end
				end
				hlls_pkg::ST_DIV: begin
					rem_q  <= rem_ge ? hlls_pkg::COUNT_W'(rem_sh - {1'b0, cnt_q}) :
						rem_sh[hlls_pkg::COUNT_W-1:0];
					quo_q  <= {quo_q[hlls_pkg::DIV_W-2:0], rem_ge};
					step_q <= step_q + 1'b1;
					if (step_q == hlls_pkg::STEP_LAST) begin
						state_q <= hlls_pkg::ST_SUM;
					end
				end
				hlls_pkg::ST_SUM: begin
					if (rsp_acc) begin
						state_q <= hlls_pkg::ST_IDLE;
					end
				end
				default: state_q <= hlls_pkg::ST_IDLE;
			endcase

			if (state_q == hlls_pkg::ST_DIV && step_q == hlls_pkg::STEP_LAST) begin
				kind         <= hlls_pkg::KIND_SUMMARY;
				value        <= max_q;
				mean_whole   <= quo_q[hlls_pkg::DIV_W-2:hlls_pkg::FRAC_BITS-1];
				mean_frac    <= {quo_q[hlls_pkg::FRAC_BITS-2:0], rem_ge};
				number_count <= cnt_q;
				last         <= 1'b1;
				max_q        <= '0;
				sum_q        <= '0;
				cnt_q        <= '0;
			end

			if (sum_start) begin
				pend_nl_q <= 1'b0;
				if (cnt_q == '0) begin
					kind         <= hlls_pkg::KIND_SUMMARY;
					value        <= '0;
					mean_whole   <= '0;
					mean_frac    <= '0;
					number_count <= '0;
					last         <= 1'b1;
					max_q        <= '0;
					sum_q        <= '0;
					state_q      <= hlls_pkg::ST_SUM;
				end else begin
					quo_q   <= {sum_q, {hlls_pkg::FRAC_BITS{1'b0}}};
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= hlls_pkg::ST_DIV;
				end
			end
		end
	end

	// result never overlaps request acceptance
	a_stall_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request accepted while result pending");

	// a literal that ends on a newline is followed by a divide or summary
	a_nl_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlls_pkg::ST_LIT && pend_nl_q && rsp_acc) |=>
		(state_q == hlls_pkg::ST_DIV || state_q == hlls_pkg::ST_SUM))
		else $error("newline summary lost after literal");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlls_pkg::ST_DIV && step_q != '0) |-> (rem_q < cnt_q))
		else $error("division remainder out of range");

	// summaries always close the byte's results
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlls_pkg::ST_SUM) |-> (kind == hlls_pkg::KIND_SUMMARY && last))
		else $error("summary result malformed");

endmodule
